// File: hw/rtl/rsi_pkg.sv
// Shared types and constants for the ray/sphere intersection pipeline.
// No dependencies; imported by the stream interfaces and the top level.
package rsi_pkg;

	localparam int COORD_W = 32;
	localparam int FIELD_W = 32;
	localparam int CW      = (COORD_W < FIELD_W) ? COORD_W : FIELD_W;
	localparam int RSQ_W   = 31;
	localparam int FRAC_W  = 16;

	localparam int PROD_W  = 2 * FIELD_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int T_W     = PROD_W;
	localparam int HALF_T  = T_W / 2;
	localparam int SQ_W    = 2 * T_W;
	localparam int SQ_N    = SQ_W / 2;
	localparam int REM_W   = T_W + 2;
	localparam int Q_W     = T_W + 1 - FRAC_W;

	localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'((65'd1 << (CW - 1)) - 65'd1);
	localparam logic signed [Q_W-1:0] SAT_MIN = ~SAT_MAX;

	typedef logic signed [FIELD_W-1:0] coord_t;
	typedef logic [RSQ_W-1:0] rsq_t;

	typedef struct packed {
		logic   hit;
		coord_t t_near;
		coord_t t_far;
	} res_t;

	typedef struct packed {
		logic             hit;
		logic [T_W-1:0]   t;
		logic [SQ_W-1:0]  x;
		logic [REM_W-1:0] rem;
		logic [T_W-1:0]   root;
	} sq_t;

endpackage

// File: hw/rtl/rsi_req_if.sv
// Input stream channel: valid/ready plus one ray/sphere word.
// Depends on rsi_pkg.
interface rsi_req_if import rsi_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t rel_x;
	coord_t rel_y;
	coord_t rel_z;
	coord_t dir_x;
	coord_t dir_y;
	coord_t dir_z;
	rsq_t   radius_sq;

	modport source (output valid, rel_x, rel_y, rel_z, dir_x, dir_y, dir_z, radius_sq,
		input ready);
	modport sink (input valid, rel_x, rel_y, rel_z, dir_x, dir_y, dir_z, radius_sq,
		output ready);
endinterface

// File: hw/rtl/rsi_rsp_if.sv
// Result stream channel: valid/ready plus hit flag and the two distances.
// Depends on rsi_pkg.
interface rsi_rsp_if import rsi_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   hit;
	coord_t t_near;
	coord_t t_far;

	modport source (output valid, hit, t_near, t_far, input ready);
	modport sink (input valid, hit, t_near, t_far, output ready);
endinterface

// File: hw/rtl/ray_sphere_intersect_top.sv
// Geometric ray/sphere intersection, Q16.16 in and out, fully pipelined.
// Throughput: one word per cycle while the skid entry is empty; the 64-stage
// square root (one root bit per stage) sets the depth. A two-entry output
// buffer keeps input open while one result waits, but not while both are full.
// Reset (arst_n, async) empties the pipeline and the output buffer.
// Depends on rsi_pkg, rsi_req_if, rsi_rsp_if.
module ray_sphere_intersect_top import rsi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rsi_req_if.sink    req,
	rsi_rsp_if.source  rsp
);

	function automatic coord_t sext_coord(coord_t f);
		logic signed [CW-1:0] lo;
		lo = f[CW-1:0];
		return FIELD_W'(lo);
	endfunction

	// one restoring square-root step: two radicand bits in, one root bit out
	function automatic sq_t sq_step(sq_t a, logic [1:0] pair);
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		sq_t r;
		r     = a;
		cur   = {a.rem, pair};
		trial = {2'b00, a.root, 2'b01};
		if (cur >= trial) begin
			r.rem  = REM_W'(cur - trial);
			r.root = {a.root[T_W-2:0], 1'b1};
		end else begin
			r.rem  = cur[REM_W-1:0];
			r.root = {a.root[T_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic en;
	logic skid_v_q;

	assign en        = !skid_v_q;
	assign req.ready = en;

	// s1: dot-product terms
	logic                     v_s1;
	logic signed [PROD_W-1:0] pd_s1 [3];
	logic [PROD_W-1:0]        pp_s1 [3];
	rsq_t                     rsq_s1;

	coord_t px, py, pz, dx, dy, dz;
	assign px = sext_coord(req.rel_x);
	assign py = sext_coord(req.rel_y);
	assign pz = sext_coord(req.rel_z);
	assign dx = sext_coord(req.dir_x);
	assign dy = sext_coord(req.dir_y);
	assign dz = sext_coord(req.dir_z);

	always_ff @(posedge clk) begin
		if (en) begin
			pd_s1[0] <= PROD_W'(px) * PROD_W'(dx);
			pd_s1[1] <= PROD_W'(py) * PROD_W'(dy);
			pd_s1[2] <= PROD_W'(pz) * PROD_W'(dz);
			pp_s1[0] <= PROD_W'(px) * PROD_W'(px);
			pp_s1[1] <= PROD_W'(py) * PROD_W'(py);
			pp_s1[2] <= PROD_W'(pz) * PROD_W'(pz);
			rsq_s1   <= req.radius_sq;
		end
	end

	// s2: sums, projection sign
	logic                    v_s2;
	logic                    ok_s2;
	logic [T_W-1:0]          t_s2;
	logic [PROD_W-1:0]       pp_s2;
	rsq_t                    rsq_s2;
	logic signed [DOT_W-1:0] dot;

	assign dot = DOT_W'(pd_s1[0]) + DOT_W'(pd_s1[1]) + DOT_W'(pd_s1[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2  <= !dot[DOT_W-1] && (dot != '0);
			t_s2   <= dot[T_W-1:0];
			pp_s2  <= PROD_W'(pp_s1[0] + pp_s1[1] + pp_s1[2]);
			rsq_s2 <= rsq_s1;
		end
	end

	// s3: partial products of t*t
	logic              v_s3;
	logic              ok_s3;
	logic [T_W-1:0]    t_s3;
	logic [PROD_W-1:0] pp_s3;
	rsq_t              rsq_s3;
	logic [T_W-1:0]    ll_s3, lh_s3, hh_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3  <= ok_s2;
			t_s3   <= t_s2;
			pp_s3  <= pp_s2;
			rsq_s3 <= rsq_s2;
			ll_s3  <= T_W'(t_s2[HALF_T-1:0]) * T_W'(t_s2[HALF_T-1:0]);
			lh_s3  <= T_W'(t_s2[HALF_T-1:0]) * T_W'(t_s2[T_W-1:HALF_T]);
			hh_s3  <= T_W'(t_s2[T_W-1:HALF_T]) * T_W'(t_s2[T_W-1:HALF_T]);
		end
	end

	// s4: rhs = t^2 + r * 2^48 at Q.64
	logic              v_s4;
	logic              ok_s4;
	logic [T_W-1:0]    t_s4;
	logic [PROD_W-1:0] pp_s4;
	logic [SQ_W-1:0]   rhs_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4  <= ok_s3;
			t_s4   <= t_s3;
			pp_s4  <= pp_s3;
			rhs_s4 <= {hh_s3, ll_s3}
				+ {{(SQ_W-T_W-HALF_T-1){1'b0}}, lh_s3, {(HALF_T+1){1'b0}}}
				+ {{(SQ_W-RSQ_W-3*FRAC_W){1'b0}}, rsq_s3, {(3*FRAC_W){1'b0}}};
		end
	end

	// s5: compare p.p against rhs, radicand
	logic            v_s5;
	logic            hit_s5;
	logic [T_W-1:0]  t_s5;
	logic [SQ_W-1:0] h2_s5;
	logic [SQ_W-1:0] lhs;

	assign lhs = {{(SQ_W-PROD_W-HALF_T){1'b0}}, pp_s4, {HALF_T{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s5 <= ok_s4 && (lhs <= rhs_s4);
			t_s5   <= t_s4;
			h2_s5  <= rhs_s4 - lhs;
		end
	end

	// s6..s69: square root, one bit per stage
	logic [SQ_N-1:0] v_s6_69;
	sq_t             sq_s6_69 [SQ_N];
	sq_t             sq_in    [SQ_N];

	assign sq_in[0] = '{hit: hit_s5, t: t_s5, x: h2_s5, rem: '0, root: '0};

	for (genvar k = 0; k < SQ_N; k++) begin : g_sq
		if (k > 0) begin : g_link
			assign sq_in[k] = sq_s6_69[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s6_69[k] <= sq_step(sq_in[k], sq_in[k].x[SQ_W-1-2*k -: 2]);
			end
		end
	end

	// s70: distances, floor to Q16.16 and saturate
	logic                v_s70;
	res_t                res_s70;
	sq_t                 sq_last;
	logic signed [T_W:0] diff;
	logic [T_W:0]        sum;
	logic signed [Q_W-1:0] qn;
	logic signed [Q_W-1:0] qf;
	res_t                res_d;

	assign sq_last = sq_s6_69[SQ_N-1];
	assign diff    = {1'b0, sq_last.t} - {1'b0, sq_last.root};
	assign sum     = {1'b0, sq_last.t} + {1'b0, sq_last.root};
	assign qn      = diff[T_W:FRAC_W];
	assign qf      = sum[T_W:FRAC_W];

	always_comb begin
		res_d = '0;
		if (sq_last.hit) begin
			res_d.hit = 1'b1;
			if (qn > SAT_MAX) begin
				res_d.t_near = FIELD_W'(SAT_MAX);
			end else if (qn < SAT_MIN) begin
				res_d.t_near = FIELD_W'(SAT_MIN);
			end else begin
				res_d.t_near = FIELD_W'(qn);
			end
			if (sum[T_W] || (qf > SAT_MAX)) begin
				res_d.t_far = FIELD_W'(SAT_MAX);
			end else begin
				res_d.t_far = FIELD_W'(qf);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s70 <= res_d;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_s6_69 <= '0;
			v_s70   <= 1'b0;
		end else if (en) begin
			v_s1    <= req.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_s6_69 <= {v_s6_69[SQ_N-2:0], v_s5};
			v_s70   <= v_s6_69[SQ_N-1];
		end
	end

	// output register with skid entry
	logic rsp_v_q;
	res_t rsp_q;
	res_t skid_q;
	logic push;
	logic out_free;

	assign push     = en && v_s70;
	assign out_free = !rsp_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_free) begin
				rsp_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (out_free) begin
				rsp_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (rsp.ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_free) begin
				rsp_q <= skid_q;
			end
		end else if (push) begin
			if (out_free) begin
				rsp_q <= res_s70;
			end else begin
				skid_q <= res_s70;
			end
		end
	end

	assign rsp.valid  = rsp_v_q;
	assign rsp.hit    = rsp_q.hit;
	assign rsp.t_near = rsp_q.t_near;
	assign rsp.t_far  = rsp_q.t_far;

endmodule
